>>> hw/rtl/spn_pkg.sv
// ----------------------------------------------------------------------------
// spn_pkg: shared types and functions of the 16-bit SPN cipher
// S-box tables, the bit-matrix transpose and the per-cell round key select.
// ----------------------------------------------------------------------------
package spn_pkg;

  localparam int unsigned BLOCK_W   = 16;
  localparam int unsigned NUM_CELLS = 4;

  localparam logic [3:0] FWD_BOX [16] = '{
    4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
  };
  localparam logic [3:0] INV_BOX [16] = '{
    4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
    4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
  };

  // Keys and routing flags for one cell, per direction.
  typedef struct packed {
    logic [BLOCK_W-1:0] enc_pre;
    logic [BLOCK_W-1:0] enc_post;
    logic               enc_perm_out;
    logic [BLOCK_W-1:0] dec_pre;
    logic [BLOCK_W-1:0] dec_post;
    logic               dec_perm_in;
  } cell_key_t;

  function automatic logic [BLOCK_W-1:0] fwd_subst(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int n = 0; n < 4; n++) begin
      r[4*n +: 4] = FWD_BOX[x[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] inv_subst(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int n = 0; n < 4; n++) begin
      r[4*n +: 4] = INV_BOX[x[4*n +: 4]];
    end
    return r;
  endfunction

  // Bit 4a+b moves to bit 4b+a.
  function automatic logic [BLOCK_W-1:0] transpose(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        r[4*b+a] = x[4*a+b];
      end
    end
    return r;
  endfunction

  // Round keys one to four from the high word, most significant first; five is the low word.
  function automatic logic [BLOCK_W-1:0] round_key(input int unsigned r,
                                                   input logic [63:0] kh,
                                                   input logic [BLOCK_W-1:0] kl);
    logic [BLOCK_W-1:0] k;
    if (r >= 5) begin
      k = kl;
    end else begin
      k = kh[64-16*r+15 -: 16];
    end
    return k;
  endfunction

  // Encrypt: cell j does T(S(x ^ K(j+1))), the last one S(x ^ K4) ^ K5.
  // Decrypt: cell 0 does S'(x ^ K5) ^ K4, cell j then S'(T(x)) ^ K(4-j).
  function automatic cell_key_t cell_keys(input int unsigned idx,
                                          input logic [63:0] kh,
                                          input logic [BLOCK_W-1:0] kl);
    cell_key_t c;
    c.enc_pre      = round_key(idx + 1, kh, kl);
    c.enc_post     = (idx == NUM_CELLS - 1) ? kl : '0;
    c.enc_perm_out = (idx != NUM_CELLS - 1);
    c.dec_pre      = (idx == 0) ? kl : '0;
    c.dec_post     = round_key(NUM_CELLS - idx, kh, kl);
    c.dec_perm_in  = (idx != 0);
    return c;
  endfunction

endpackage

>>> hw/rtl/spn_round_cell.sv
// ----------------------------------------------------------------------------
// spn_round_cell: one round of the cipher with its pipeline register
// Takes the block from the upstream neighbor and hands the result downstream.
// ----------------------------------------------------------------------------
module spn_round_cell
  import spn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_key_t          keys,
  input  logic               up_valid,
  input  logic               up_action,
  input  logic [BLOCK_W-1:0] up_block,
  input  logic               down_move,
  output logic               move,
  output logic               valid,
  output logic               action,
  output logic [BLOCK_W-1:0] block
);

  logic [BLOCK_W-1:0] pre;
  logic [BLOCK_W-1:0] mid;
  logic [BLOCK_W-1:0] sub;
  logic [BLOCK_W-1:0] post;
  logic [BLOCK_W-1:0] block_next;

  // Load when empty or when the neighbor takes what is held.
  assign move = !valid || down_move;

  always_comb begin
    pre  = up_block ^ (up_action ? keys.dec_pre : keys.enc_pre);
    mid  = (up_action && keys.dec_perm_in) ? transpose(pre) : pre;
    sub  = up_action ? inv_subst(mid) : fwd_subst(mid);
    post = sub ^ (up_action ? keys.dec_post : keys.enc_post);
    block_next = (!up_action && keys.enc_perm_out) ? transpose(post) : post;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (move) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move && up_valid) begin
      action <= up_action;
      block  <= block_next;
    end
  end

endmodule

>>> hw/rtl/spn_block_cipher_16bit.sv
// ----------------------------------------------------------------------------
// spn_block_cipher_16bit: pipelined 16-bit SPN block cipher, 80-bit key
// Four round cells in a row encrypt or decrypt one block per clock while the output is not stalled.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   --------  ------------------------  --------------------------------
//   config    psel/penable/pready       paddr[3:0], pwdata/prdata[63:0]
//   input     in_valid / in_stall       action, block_in[15:0]
//   output    out_valid / out_stall     block_out[15:0]
//
// One request enters per clock unless in_stall is high; its result passes through
// the four round cells in the chain and leaves from the last one.
// Reset (rst, synchronous) clears every cell's valid bit and both keys.
// A stalled output holds in the last cell; earlier cells keep filling empty
// slots, and in_stall rises only once the whole chain is full.
// Key words sit at byte address 0 (key_high) and 8 (key_low); address bit 3
// alone selects the word.
//
module spn_block_cipher_16bit
  import spn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [BLOCK_W-1:0] block_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BLOCK_W-1:0] block_out
);

  logic [63:0]        key_high;
  logic [BLOCK_W-1:0] key_low;

  // Per-cell handshake and data, index 0 is the request entering the chain.
  logic               chain_valid  [NUM_CELLS+1];
  logic               chain_action [NUM_CELLS+1];
  logic [BLOCK_W-1:0] chain_block  [NUM_CELLS+1];
  logic               chain_move   [NUM_CELLS+1];

  // Configuration: no wait states, write on the access phase.
  assign pready = 1'b1;
  assign prdata = paddr[3] ? {{(64-BLOCK_W){1'b0}}, key_low} : key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3]) begin
        key_low <= pwdata[BLOCK_W-1:0];
      end else begin
        key_high <= pwdata;
      end
    end
  end

  // Feed the first cell from the input port.
  assign chain_valid[0]  = in_valid;
  assign chain_action[0] = action;
  assign chain_block[0]  = block_in;
  assign in_stall        = !chain_move[0];

  // The last cell drains when the consumer is not stalling.
  assign chain_move[NUM_CELLS] = !out_stall;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    cell_key_t keys;
    assign keys = cell_keys(g, key_high, key_low);

    spn_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .keys      (keys),
      .up_valid  (chain_valid[g]),
      .up_action (chain_action[g]),
      .up_block  (chain_block[g]),
      .down_move (chain_move[g+1]),
      .move      (chain_move[g]),
      .valid     (chain_valid[g+1]),
      .action    (chain_action[g+1]),
      .block     (chain_block[g+1])
    );
  end

  // The last cell's register is the output register.
  assign out_valid = chain_valid[NUM_CELLS];
  assign block_out = chain_block[NUM_CELLS];

endmodule

>>> hw/rtl/spn_checker.sv
// ----------------------------------------------------------------------------
// spn_checker: port-level assertions for the SPN cipher
// Checks reset, backpressure, pipeline latency and pready seen at the top-level ports.
// ----------------------------------------------------------------------------
module spn_checker
  import spn_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [BLOCK_W-1:0] block_out
);

  // Reset empties the chain.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Input backpressure only comes from a full chain behind a stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(block_out)))
    else $error("stalled result changed");

  // An accepted request reaches the output when the output does not stall in the meantime.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
    |=> out_valid)
    else $error("request did not reach the output");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind spn_block_cipher_16bit spn_checker u_spn_checker (.*);
